FILE: design/pdx_pkg.sv
// shared constants, codes and types for the proximity dedup expiry table
package pdx_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int POS_W     = 16;
    localparam int TIME_W    = 16;
    localparam int DIST_W    = 12;
    localparam int R2_W      = 2 * DIST_W;
    localparam int SQ_W      = 2 * POS_W;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 7;

    // entry word layout: x lowest, then y, then timer
    localparam int X_LSB   = 0;
    localparam int Y_LSB   = X_LSB + POS_W;
    localparam int T_LSB   = Y_LSB + POS_W;
    localparam int ENTRY_W = T_LSB + TIME_W;

    // stream packing
    localparam int S_TDATA_W = 2 * POS_W + 2 * TIME_W;
    localparam int M_TDATA_W = ((2 * OUT_CNT_W + 7) / 8) * 8;

    // cycles from the last entry read to the final distance compare
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    // reset value of the suppression radius, 10.0 in Q8.4
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(160);

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CLOSE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TICK  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/pdx_ram.sv
// generic simple dual port ram, one write port and one registered read port
module pdx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pdx_ctrl.sv
// sequencer: accepts an item, sweeps the table, drains the pipe, posts the result
module pdx_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  pdx_pkg::t_dp_status i_status,
    output pdx_pkg::t_ctl_cmd   o_cmd
);

    pdx_pkg::t_state               r_state;
    pdx_pkg::t_state               n_state;
    logic [pdx_pkg::ADDR_W-1:0]    r_addr;
    logic [pdx_pkg::ADDR_W-1:0]    n_addr;
    logic [pdx_pkg::DRAIN_W-1:0]   r_drain;
    logic [pdx_pkg::DRAIN_W-1:0]   n_drain;
    logic                          last_addr;
    logic                          last_drain;

    assign last_addr  = (r_addr == pdx_pkg::ADDR_W'(pdx_pkg::CAPACITY - 1));
    assign last_drain = (r_drain == pdx_pkg::DRAIN_W'(pdx_pkg::DRAIN_CYCLES - 1));

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_drain = r_drain;
        case (r_state)
            pdx_pkg::ST_IDLE: begin
                n_addr = '0;
                if (i_item_valid) begin
                    n_state = pdx_pkg::ST_SWEEP;
                end
            end
            pdx_pkg::ST_SWEEP: begin
                n_drain = '0;
                if (last_addr) begin
                    n_state = pdx_pkg::ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            pdx_pkg::ST_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (last_drain) begin
                    n_state = pdx_pkg::ST_FINISH;
                end
            end
            pdx_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = pdx_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdx_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_item_ready  = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_addr = r_addr;
        o_cmd.finish  = 1'b0;
        case (r_state)
            pdx_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.load   = i_item_valid;
            end
            pdx_pkg::ST_SWEEP: begin
                o_cmd.rd_en = 1'b1;
            end
            pdx_pkg::ST_DRAIN: begin
                o_cmd.rd_en = 1'b0;
            end
            pdx_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdx_pkg::ST_IDLE;
            r_addr  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_drain <= n_drain;
        end
    end

endmodule

FILE: design/pdx_dpath.sv
// datapath: item latch, entry ram, distance pipe, expiry, counts and result register
module pdx_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pdx_pkg::t_ctl_cmd                    i_cmd,
    output pdx_pkg::t_dp_status                  o_status,
    input  logic                                 i_cfg_valid,
    input  logic [pdx_pkg::DIST_W-1:0]           i_cfg_data,
    input  logic                                 i_item_cmd,
    input  logic [pdx_pkg::POS_W-1:0]            i_pos_x,
    input  logic [pdx_pkg::POS_W-1:0]            i_pos_y,
    input  logic [pdx_pkg::TIME_W-1:0]           i_lifetime,
    input  logic [pdx_pkg::TIME_W-1:0]           i_elapsed,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [pdx_pkg::STATUS_W-1:0]         o_status_code,
    output logic [pdx_pkg::OUT_CNT_W-1:0]        o_entry_count,
    output logic [pdx_pkg::OUT_CNT_W-1:0]        o_removed_count
);

    // config
    logic [pdx_pkg::DIST_W-1:0]    r_min_dist;
    logic [pdx_pkg::R2_W-1:0]      r_r2;

    // latched item
    logic                          r_cmd;
    logic [pdx_pkg::POS_W-1:0]     r_px;
    logic [pdx_pkg::POS_W-1:0]     r_py;
    logic [pdx_pkg::TIME_W-1:0]    r_life;
    logic [pdx_pkg::TIME_W-1:0]    r_el;

    // table state
    logic                          r_valid [pdx_pkg::CAPACITY];
    logic [pdx_pkg::CNT_W-1:0]     r_live;
    logic [pdx_pkg::CNT_W-1:0]     n_live;

    // sweep pipe
    logic                          r_p1_vld;
    logic [pdx_pkg::ADDR_W-1:0]    r_p1_idx;
    logic                          r_p2_vld;
    logic [pdx_pkg::POS_W-1:0]     r_adx;
    logic [pdx_pkg::POS_W-1:0]     r_ady;
    logic                          r_p3_vld;
    logic [pdx_pkg::SQ_W-1:0]      r_sqx;
    logic [pdx_pkg::SQ_W-1:0]      r_sqy;

    // sweep results
    logic                          r_close;
    logic                          r_found;
    logic [pdx_pkg::ADDR_W-1:0]    r_slot;
    logic [pdx_pkg::CNT_W-1:0]     r_removed;

    // result register
    logic                          r_res_valid;
    logic [pdx_pkg::STATUS_W-1:0]  r_res_status;
    logic [pdx_pkg::OUT_CNT_W-1:0] r_res_count;
    logic [pdx_pkg::OUT_CNT_W-1:0] r_res_removed;

    logic [pdx_pkg::ENTRY_W-1:0]   rdata;
    logic [pdx_pkg::POS_W-1:0]     e_x;
    logic [pdx_pkg::POS_W-1:0]     e_y;
    logic [pdx_pkg::TIME_W-1:0]    e_t;
    logic                          e_vld;
    logic signed [pdx_pkg::POS_W:0] dx;
    logic signed [pdx_pkg::POS_W:0] dy;
    logic [pdx_pkg::POS_W:0]       adx_w;
    logic [pdx_pkg::POS_W:0]       ady_w;
    logic [pdx_pkg::SQ_W:0]        d2;
    logic                          tick_live;
    logic                          tick_exp;
    logic                          tick_wr;
    logic                          add_commit;
    logic                          ram_we;
    logic [pdx_pkg::ADDR_W-1:0]    ram_waddr;
    logic [pdx_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [pdx_pkg::STATUS_W-1:0]  fin_status;

    pdx_ram #(
        .WIDTH (pdx_pkg::ENTRY_W),
        .DEPTH (pdx_pkg::CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rdata)
    );

    assign e_x   = rdata[pdx_pkg::X_LSB +: pdx_pkg::POS_W];
    assign e_y   = rdata[pdx_pkg::Y_LSB +: pdx_pkg::POS_W];
    assign e_t   = rdata[pdx_pkg::T_LSB +: pdx_pkg::TIME_W];
    assign e_vld = r_valid[r_p1_idx];

    // absolute differences, at most 65535 so 16 bits hold them
    assign dx    = $signed({e_x[pdx_pkg::POS_W-1], e_x}) - $signed({r_px[pdx_pkg::POS_W-1], r_px});
    assign dy    = $signed({e_y[pdx_pkg::POS_W-1], e_y}) - $signed({r_py[pdx_pkg::POS_W-1], r_py});
    assign adx_w = dx[pdx_pkg::POS_W] ? 17'(-dx) : 17'(dx);
    assign ady_w = dy[pdx_pkg::POS_W] ? 17'(-dy) : 17'(dy);

    assign d2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    // expiry on a tick, decided as each entry comes out of the ram
    assign tick_live = r_p1_vld && (r_cmd == pdx_pkg::CMD_TICK) && e_vld;
    assign tick_exp  = tick_live && (r_el >= e_t);
    assign tick_wr   = tick_live && (r_el < e_t);

    assign add_commit = i_cmd.finish && (r_cmd == pdx_pkg::CMD_ADD) && !r_close && r_found;

    always_comb begin
        ram_we    = tick_wr || add_commit;
        ram_waddr = r_p1_idx;
        ram_wdata = {e_t - r_el, e_y, e_x};
        if (add_commit) begin
            ram_waddr = r_slot;
            ram_wdata = {r_life, r_py, r_px};
        end
    end

    always_comb begin
        n_live = r_live;
        if (tick_exp) begin
            n_live = r_live - 1'b1;
        end else if (add_commit) begin
            n_live = r_live + 1'b1;
        end
    end

    always_comb begin
        if (r_cmd == pdx_pkg::CMD_TICK) begin
            fin_status = pdx_pkg::STAT_TICK;
        end else if (r_close) begin
            fin_status = pdx_pkg::STAT_CLOSE;
        end else if (r_found) begin
            fin_status = pdx_pkg::STAT_ADDED;
        end else begin
            fin_status = pdx_pkg::STAT_FULL;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= pdx_pkg::MIN_DIST_RESET;
            r_live      <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_p3_vld    <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < pdx_pkg::CAPACITY; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_min_dist <= i_cfg_data;
            end
            r_live   <= n_live;
            r_p1_vld <= i_cmd.rd_en;
            r_p2_vld <= r_p1_vld && (r_cmd == pdx_pkg::CMD_ADD) && e_vld;
            r_p3_vld <= r_p2_vld;
            if (tick_exp) begin
                r_valid[r_p1_idx] <= 1'b0;
            end
            if (add_commit) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_r2     <= r_min_dist * r_min_dist;
        r_p1_idx <= i_cmd.rd_addr;
        r_adx    <= adx_w[pdx_pkg::POS_W-1:0];
        r_ady    <= ady_w[pdx_pkg::POS_W-1:0];
        r_sqx    <= r_adx * r_adx;
        r_sqy    <= r_ady * r_ady;
        if (i_cmd.load) begin
            r_cmd     <= i_item_cmd;
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_life    <= i_lifetime;
            r_el      <= i_elapsed;
            r_close   <= 1'b0;
            r_found   <= 1'b0;
            r_slot    <= '0;
            r_removed <= '0;
        end else begin
            if (r_p3_vld && (d2 < {{(pdx_pkg::SQ_W + 1 - pdx_pkg::R2_W){1'b0}}, r_r2})) begin
                r_close <= 1'b1;
            end
            // lowest free slot
            if (r_p1_vld && !e_vld && !r_found) begin
                r_found <= 1'b1;
                r_slot  <= r_p1_idx;
            end
            if (tick_exp) begin
                r_removed <= r_removed + 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_res_status  <= fin_status;
            r_res_count   <= pdx_pkg::OUT_CNT_W'(n_live);
            r_res_removed <= (r_cmd == pdx_pkg::CMD_TICK) ?
                             pdx_pkg::OUT_CNT_W'(r_removed) : '0;
        end
    end

    assign o_status.out_free = !r_res_valid || i_res_ready;
    assign o_res_valid       = r_res_valid;
    assign o_status_code     = r_res_status;
    assign o_entry_count     = r_res_count;
    assign o_removed_count   = r_res_removed;

endmodule

FILE: design/proximity_dedup_expiry_table.sv
// top level of the proximity dedup expiry table
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: command; tdata: pos_x, pos_y,
//                                                lifetime, elapsed
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser: status; tdata: entry_count,
//                                                removed_count
// cfg       in   i_cfg_valid / o_cfg_ready       min_distance
//
// every item, add or tick, sweeps all CAPACITY entries through the single read port
// of the entry ram, one entry per cycle, then drains a three stage distance pipe;
// the next item is accepted only once the result of this one has been posted
// reset is synchronous active low; valid bits, live count and min_distance (10.0)
// are cleared at once, no clearing pass is needed
// the result sits in an output register, so a new item is taken while it waits;
// the following result is held back until the previous one is taken
module proximity_dedup_expiry_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pdx_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // pos_x, pos_y, lifetime, elapsed
    input  logic [0:0]                         s_axis_tuser,  // command
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pdx_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // entry_count, removed_count, pad
    output logic [pdx_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    // min_distance register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pdx_pkg::DIST_W-1:0]         i_cfg_data
);

    pdx_pkg::t_ctl_cmd              ctl_cmd;
    pdx_pkg::t_dp_status            dp_status;
    logic [pdx_pkg::OUT_CNT_W-1:0]  entry_count;
    logic [pdx_pkg::OUT_CNT_W-1:0]  removed_count;

    // config writes are to be made only while idle; the block does not enforce this, o_cfg_ready is tied high
    assign o_cfg_ready = 1'b1;

    pdx_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_status     (dp_status),
        .o_cmd        (ctl_cmd)
    );

    pdx_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_status        (dp_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_item_cmd      (s_axis_tuser[0]),
        .i_pos_x         (s_axis_tdata[pdx_pkg::POS_W-1:0]),
        .i_pos_y         (s_axis_tdata[2*pdx_pkg::POS_W-1:pdx_pkg::POS_W]),
        .i_lifetime      (s_axis_tdata[2*pdx_pkg::POS_W+pdx_pkg::TIME_W-1:2*pdx_pkg::POS_W]),
        .i_elapsed       (s_axis_tdata[pdx_pkg::S_TDATA_W-1:2*pdx_pkg::POS_W+pdx_pkg::TIME_W]),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_status_code   (m_axis_tuser),
        .o_entry_count   (entry_count),
        .o_removed_count (removed_count)
    );

    // entry_count lowest, removed_count next, zero pad to a whole byte
    assign m_axis_tdata = {{(pdx_pkg::M_TDATA_W - 2 * pdx_pkg::OUT_CNT_W){1'b0}},
                           removed_count, entry_count};

endmodule
